// ----- src/assert_macros.svh -----
// Assertion helpers shared by the calendar clock modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Holds at every clock edge outside reset.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition in one cycle implies the result in the next one.
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ----- src/ccc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccc_pkg
// Types, constants and the month-length table of the calendar clock counter.
// ----------------------------------------------------------------------------
package ccc_pkg;

    typedef struct packed {
        logic        mode;
        logic [13:0] new_year;
        logic [8:0]  new_day_of_year;
        logic [4:0]  new_hour;
        logic [5:0]  new_minute;
    } t_in_item;

    typedef struct packed {
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [8:0]  day_of_year;
        logic [13:0] year;
        logic        is_leap;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic        refresh_display;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic leap_quot;
        logic leap_eval;
        logic month_step;
        logic emit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic month_done;
        logic out_free;
    } t_dp_status;

    localparam logic        MODE_TICK = 1'b0;
    localparam logic        MODE_SET  = 1'b1;

    localparam logic [2:0]  DM_MIN_SEC    = 3'd0;
    localparam logic [2:0]  DM_HOUR_MIN   = 3'd1;
    localparam logic [2:0]  DM_DAY_MONTH  = 3'd2;
    localparam logic [2:0]  DM_YEAR       = 3'd3;

    localparam logic        REG_DISPLAY_MODE = 1'b0;

    localparam logic [6:0]  SEC_PER_MIN   = 7'd60;
    localparam logic [6:0]  MIN_PER_HOUR  = 7'd60;
    localparam logic [5:0]  HOUR_PER_DAY  = 6'd24;
    localparam logic [9:0]  DAYS_NORMAL   = 10'd365;
    localparam logic [13:0] YEAR_LAST     = 14'd9999;
    localparam logic [12:0] RECIP_25      = 13'd5243;
    localparam logic [3:0]  LAST_MONTH    = 4'd11;
    localparam logic [4:0]  DAY_MAX       = 5'd31;

    localparam logic [8:0]  RST_YDAY      = 9'd283;
    localparam logic [13:0] RST_YEAR      = 14'd2020;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        begin
            case (m)
                4'd0:    len = 5'd31;
                4'd1:    len = leap ? 5'd29 : 5'd28;
                4'd2:    len = 5'd31;
                4'd3:    len = 5'd30;
                4'd4:    len = 5'd31;
                4'd5:    len = 5'd30;
                4'd6:    len = 5'd31;
                4'd7:    len = 5'd31;
                4'd8:    len = 5'd30;
                4'd9:    len = 5'd31;
                4'd10:   len = 5'd30;
                default: len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

// ----- src/ccc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccc_ctrl
// Sequencer of the calendar clock: accepts an item, runs the leap check and
// the month walk, and hands the result to the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ccc_ctrl
    import ccc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LEAPQ = 5'b00010,
        S_LEAPR = 5'b00100,
        S_MONTH = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_LEAPQ;
                end
            end
            S_LEAPQ: begin
                o_cmd.leap_quot = 1'b1;
                n_state         = S_LEAPR;
            end
            S_LEAPR: begin
                o_cmd.leap_eval = 1'b1;
                n_state         = S_MONTH;
            end
            S_MONTH: begin
                if (i_status.month_done) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.month_step = 1'b1;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    `ASSERT_NEXT(a_accept_to_leap, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_state == S_LEAPQ, "accepted item did not start the leap check")
    `ASSERT_NEXT(a_leap_to_walk, i_clk, i_rst_n, r_state == S_LEAPR, r_state == S_MONTH, "leap check did not lead to the month walk")
    `ASSERT_NEXT(a_emit_to_idle, i_clk, i_rst_n, r_state == S_EMIT && i_status.out_free, r_state == S_IDLE && !o_in_stall, "controller did not return to idle after handing off")

endmodule

// ----- src/ccc_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccc_datapath
// Time counters with carry chain, leap-year check by reciprocal multiply,
// one-entry-per-cycle month walk, and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ccc_datapath
    import ccc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_item   i_in_item,
    input  logic [2:0] i_display_mode,
    input  t_ctrl_cmd  i_cmd,
    output t_dp_status o_status,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_item
);

    logic [5:0]  r_sec;
    logic [5:0]  r_min;
    logic [4:0]  r_hour;
    logic [8:0]  r_yday;
    logic [13:0] r_year;
    logic        r_leap;
    logic        r_refresh;
    logic [9:0]  r_quot;
    logic [9:0]  r_d;
    logic [3:0]  r_m;
    logic        r_out_valid;
    t_out_item   r_out;

    logic [5:0]  n_sec;
    logic [5:0]  n_min;
    logic [4:0]  n_hour;
    logic [8:0]  n_yday;
    logic [13:0] n_year;
    logic        n_refresh;

    logic [6:0]  w_sec_inc;
    logic [6:0]  w_min_inc;
    logic [5:0]  w_hour_inc;
    logic [9:0]  w_yday_inc;
    logic        w_sec_wrap;
    logic        w_min_wrap;
    logic        w_hour_wrap;
    logic        w_yday_wrap;
    logic [26:0] w_prod;
    logic [13:0] w_quot25;
    logic        w_div25;
    logic [4:0]  w_len;

    assign w_sec_inc   = {1'b0, r_sec} + 7'd1;
    assign w_min_inc   = {1'b0, r_min} + 7'd1;
    assign w_hour_inc  = {1'b0, r_hour} + 6'd1;
    assign w_yday_inc  = {1'b0, r_yday} + 10'd1;
    assign w_sec_wrap  = (w_sec_inc >= SEC_PER_MIN);
    assign w_min_wrap  = (w_min_inc >= MIN_PER_HOUR);
    assign w_hour_wrap = (w_hour_inc >= HOUR_PER_DAY);
    assign w_yday_wrap = (w_yday_inc >= (DAYS_NORMAL + {9'd0, r_leap}));

    always_comb begin
        n_sec     = r_sec;
        n_min     = r_min;
        n_hour    = r_hour;
        n_yday    = r_yday;
        n_year    = r_year;
        n_refresh = 1'b0;
        if (i_in_item.mode == MODE_SET) begin
            n_year = i_in_item.new_year;
            n_yday = i_in_item.new_day_of_year;
            n_hour = i_in_item.new_hour;
            n_min  = i_in_item.new_minute;
            n_sec  = '0;
        end else begin
            n_sec = w_sec_wrap ? 6'd0 : w_sec_inc[5:0];
            if (w_sec_wrap) begin
                n_min = w_min_wrap ? 6'd0 : w_min_inc[5:0];
                if (w_min_wrap) begin
                    n_hour = w_hour_wrap ? 5'd0 : w_hour_inc[4:0];
                    if (w_hour_wrap) begin
                        n_yday = w_yday_wrap ? 9'd0 : w_yday_inc[8:0];
                        if (w_yday_wrap) begin
                            n_year = (r_year >= YEAR_LAST) ? 14'd0 : r_year + 14'd1;
                        end
                    end
                end
            end
            case (i_display_mode)
                DM_MIN_SEC:   n_refresh = 1'b1;
                DM_HOUR_MIN:  n_refresh = w_sec_wrap;
                DM_DAY_MONTH: n_refresh = w_sec_wrap && w_min_wrap && w_hour_wrap;
                DM_YEAR:      n_refresh = w_sec_wrap && w_min_wrap && w_hour_wrap
                                          && w_yday_wrap;
                default:      n_refresh = 1'b0;
            endcase
        end
    end

    // A year is a multiple of 25 exactly when it equals 25 times its scaled quotient.
    assign w_prod   = {13'd0, r_year} * {14'd0, RECIP_25};
    assign w_quot25 = 14'({r_quot, 4'b0000}) + 14'({r_quot, 3'b000}) + 14'(r_quot);
    assign w_div25  = (w_quot25 == r_year);

    assign w_len = month_len(r_m, r_leap);

    assign o_status.month_done = (r_m == LAST_MONTH) || (r_d <= {5'd0, w_len});
    assign o_status.out_free   = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec  <= '0;
            r_min  <= '0;
            r_hour <= '0;
            r_yday <= RST_YDAY;
            r_year <= RST_YEAR;
            r_leap <= 1'b1;
        end else if (i_cmd.load) begin
            r_sec  <= n_sec;
            r_min  <= n_min;
            r_hour <= n_hour;
            r_yday <= n_yday;
            r_year <= n_year;
        end else if (i_cmd.leap_eval) begin
            r_leap <= (r_year[1:0] == 2'b00) && (!w_div25 || (r_year[3:2] == 2'b00));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_refresh <= n_refresh;
        end
        if (i_cmd.leap_quot) begin
            r_quot <= w_prod[26:17];
        end
        if (i_cmd.leap_eval) begin
            r_d <= {1'b0, r_yday} + 10'd1;
            r_m <= '0;
        end else if (i_cmd.month_step) begin
            r_d <= r_d - {5'd0, w_len};
            r_m <= r_m + 4'd1;
        end
        if (i_cmd.emit) begin
            r_out.second          <= r_sec;
            r_out.minute          <= r_min;
            r_out.hour            <= r_hour;
            r_out.day_of_year     <= r_yday;
            r_out.year            <= r_year;
            r_out.is_leap         <= r_leap;
            r_out.month           <= r_m + 4'd1;
            r_out.day_of_month    <= (r_d > {5'd0, DAY_MAX}) ? DAY_MAX : r_d[4:0];
            r_out.refresh_display <= r_refresh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `ASSERT_NEXT(a_emit_shows, i_clk, i_rst_n, i_cmd.emit, o_out_valid, "handed-off result is not shown")
    `ASSERT_RST(a_month_range, i_clk, i_rst_n, !r_out_valid || (r_out.month >= 4'd1 && r_out.month <= 4'd12 && r_out.day_of_month != 5'd0), "month or day of month out of range")
    `ASSERT_RST(a_second_range, i_clk, i_rst_n, !r_out_valid || r_out.second < 6'd60, "seconds out of range")

endmodule

// ----- src/calendar_clock_counter.sv -----
`timescale 1ns / 1ps
// An accepted item passes the leap quotient, leap evaluation, month walk and emit states before
// its result is registered; the month walk visits one table entry per cycle and takes k steps,
// k being the zero-based month (0..11). An item is accepted while the previous result still waits
// in the output register. Reset (synchronous, active low): 00:00:00 on day 283 of 2020, leap flag
// set, display mode 0, no result pending.
// ----------------------------------------------------------------------------
// calendar_clock_counter
// Real-time clock and calendar with Gregorian leap rule, month and day of
// month lookup, display refresh pulse, and an APB-style mode register.
// ----------------------------------------------------------------------------
module calendar_clock_counter
    import ccc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [2:0]  r_display_mode;
    logic        w_reg_hit;
    t_ctrl_cmd   w_cmd;
    t_dp_status  w_status;

    assign pready    = 1'b1;
    assign w_reg_hit = (paddr[2] == REG_DISPLAY_MODE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_mode <= DM_MIN_SEC;
        end else if (psel && penable && pwrite && pready && w_reg_hit) begin
            r_display_mode <= pwdata[2:0];
        end
    end

    assign prdata = w_reg_hit ? {29'd0, r_display_mode} : 32'd0;

    ccc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    ccc_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_item      (i_in_item),
        .i_display_mode (r_display_mode),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_item     (o_out_item)
    );

endmodule
